### rtl/crt_pkg.sv
// Shared types, field widths, request and register codes for the chunk reassembly tracker.
// Used by crt_ctrl, crt_dp and chunk_reassembly_tracker; depends on nothing else.
`default_nettype none

package crt_pkg;

    // Default table geometry.
    localparam int IMAGES_DEF = 16;
    localparam int CHUNKS_DEF = 64;

    // Port field widths.
    localparam int REQ_W      = 2;
    localparam int ID_W       = 8;
    localparam int OFF_W      = 24;
    localparam int LEN_W      = 16;
    localparam int HANDLE_W   = 32;
    localparam int RSLOT_W    = 6;
    localparam int SLOT_OUT_W = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int MASK_W     = 16;
    localparam int BYTES_W    = 25;
    localparam int OSIZE_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CHUNK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;

    localparam logic [OSIZE_W-1:0] OSIZE_RESET = 24'd602112;
    localparam logic               HOLD_RESET  = 1'b0;

    typedef enum logic [1:0] {
        ENT_FREE  = 2'd0,
        ENT_OPEN  = 2'd1,
        ENT_READY = 2'd2
    } entry_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the input transfer
        logic exec;     // update the entry table and build the result
        logic fill;     // take the descriptor from the memory read register
        logic load;     // move the result into the output register
    } crt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;  // current item is a read of a written slot
        logic out_free;   // output register can take a result this cycle
    } crt_stat_t;

endpackage

`default_nettype wire

### rtl/crt_ctrl.sv
// Sequencing state machine of the chunk reassembly tracker.
// Depends on crt_pkg for the command and status structs.
`default_nettype none

module crt_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output crt_pkg::crt_cmd_t        cmd,
    input  wire crt_pkg::crt_stat_t  stat
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_READ   = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_read ? S_READ : S_COMMIT;
            end
            S_READ: begin
                cmd.fill   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/crt_dp.sv
// Datapath of the chunk reassembly tracker: configuration registers, entry table,
// descriptor memory, result and output registers. Depends on crt_pkg.
`default_nettype none

module crt_dp #(
    parameter int IMAGES = crt_pkg::IMAGES_DEF,
    parameter int CHUNKS = crt_pkg::CHUNKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire crt_pkg::crt_cmd_t                 cmd,
    output crt_pkg::crt_stat_t                     stat,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [crt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [crt_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [crt_pkg::ID_W-1:0]          s_object_id,
    input  wire logic [crt_pkg::OFF_W-1:0]         s_chunk_offset,
    input  wire logic [crt_pkg::LEN_W-1:0]         s_chunk_bytes,
    input  wire logic [crt_pkg::HANDLE_W-1:0]      s_buffer_handle,
    input  wire logic [crt_pkg::RSLOT_W-1:0]       s_read_slot,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_accepted,
    output logic [crt_pkg::SLOT_OUT_W-1:0]         m_chunk_slot,
    output logic                                   m_object_ready,
    output logic [crt_pkg::MASK_W-1:0]             m_complete_mask,
    output logic                                   m_hold_flag,
    output logic [crt_pkg::CNT_OUT_W-1:0]          m_chunk_count,
    output logic [crt_pkg::HANDLE_W-1:0]           m_desc_handle,
    output logic [crt_pkg::OFF_W-1:0]              m_desc_offset,
    output logic [crt_pkg::LEN_W-1:0]              m_desc_bytes,
    output logic                                   m_rejected
);

    localparam int IDX_W  = (IMAGES > 1) ? $clog2(IMAGES) : 1;
    localparam int CW     = $clog2(CHUNKS + 1);
    localparam int DEPTH  = IMAGES * CHUNKS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW   = CW + crt_pkg::RSLOT_W;
    localparam int DESC_W = crt_pkg::HANDLE_W + crt_pkg::OFF_W + crt_pkg::LEN_W;

    // Configuration registers.
    logic [crt_pkg::OSIZE_W-1:0] osize_reg;
    logic                        hold_reg;

    // Captured input item.
    logic [crt_pkg::REQ_W-1:0]    req_reg;
    logic [crt_pkg::ID_W-1:0]     id_reg;
    logic [crt_pkg::OFF_W-1:0]    off_reg;
    logic [crt_pkg::LEN_W-1:0]    len_reg;
    logic [crt_pkg::HANDLE_W-1:0] handle_reg;
    logic [crt_pkg::RSLOT_W-1:0]  rslot_reg;

    // Entry table.
    crt_pkg::entry_status_t       status_reg [IMAGES];
    logic [crt_pkg::BYTES_W-1:0]  bytes_reg  [IMAGES];
    logic [CW-1:0]                chunks_reg [IMAGES];
    logic [IMAGES-1:0]            ready_reg;

    // Descriptor memory.
    logic [DESC_W-1:0] desc_mem [DEPTH];
    logic [DESC_W-1:0] mem_q_reg;

    // Result register.
    logic                            res_accepted_reg;
    logic [crt_pkg::SLOT_OUT_W-1:0]  res_slot_reg;
    logic                            res_object_ready_reg;
    logic [crt_pkg::MASK_W-1:0]      res_mask_reg;
    logic                            res_hold_reg;
    logic [crt_pkg::CNT_OUT_W-1:0]   res_count_reg;
    logic [DESC_W-1:0]               res_desc_reg;
    logic                            res_rejected_reg;

    // Output register.
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic                            m_accepted_reg;
    logic [crt_pkg::SLOT_OUT_W-1:0]  m_slot_reg;
    logic                            m_object_ready_reg;
    logic [crt_pkg::MASK_W-1:0]      m_mask_reg;
    logic                            m_hold_reg;
    logic [crt_pkg::CNT_OUT_W-1:0]   m_count_reg;
    logic [DESC_W-1:0]               m_desc_reg;
    logic                            m_rejected_reg;

    // Item evaluation.
    logic                            id_ok;
    logic [IDX_W-1:0]                idx;
    crt_pkg::entry_status_t          cur_status;
    logic [crt_pkg::BYTES_W-1:0]     cur_bytes;
    logic [CW-1:0]                   cur_chunks;
    logic                            is_chunk;
    logic                            is_read;
    logic                            is_release;
    logic                            reopen;
    logic                            eff_open;
    logic [CW-1:0]                   eff_chunks;
    logic                            store;
    logic [crt_pkg::BYTES_W-1:0]     sum_bytes;
    logic [CW-1:0]                   inc_chunks;
    logic                            complete;
    logic                            rd_ok;
    logic [AW-1:0]                   base_addr;
    logic [AW-1:0]                   wr_addr;
    logic [AW-1:0]                   rd_addr;
    logic [IMAGES-1:0]               ready_after;
    logic [IMAGES+crt_pkg::MASK_W-1:0]        mask_ext;
    logic [CW-1:0]                   count_val;
    logic [CW+crt_pkg::CNT_OUT_W-1:0]         count_ext;
    logic [CW+crt_pkg::SLOT_OUT_W-1:0]        slot_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osize_reg <= crt_pkg::OSIZE_RESET;
            hold_reg  <= crt_pkg::HOLD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                crt_pkg::CFG_OBJ_SIZE: osize_reg <= cfg_data;
                crt_pkg::CFG_HOLD:     hold_reg  <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= s_req_type;
            id_reg     <= s_object_id;
            off_reg    <= s_chunk_offset;
            len_reg    <= s_chunk_bytes;
            handle_reg <= s_buffer_handle;
            rslot_reg  <= s_read_slot;
        end
    end

    assign id_ok      = (id_reg < crt_pkg::ID_W'(IMAGES));
    assign idx        = id_reg[IDX_W-1:0];
    assign cur_status = status_reg[idx];
    assign cur_bytes  = bytes_reg[idx];
    assign cur_chunks = chunks_reg[idx];
    assign is_chunk   = (req_reg == crt_pkg::REQ_CHUNK);
    assign is_read    = (req_reg == crt_pkg::REQ_READ);
    assign is_release = (req_reg == crt_pkg::REQ_RELEASE);

    // A free entry, or one that has collected no bytes, starts over.
    assign reopen     = (cur_status == crt_pkg::ENT_FREE) || (cur_bytes == '0);
    assign eff_open   = reopen || (cur_status == crt_pkg::ENT_OPEN);
    assign eff_chunks = reopen ? '0 : cur_chunks;
    assign store      = eff_open && (eff_chunks < CW'(CHUNKS));
    assign sum_bytes  = cur_bytes + crt_pkg::BYTES_W'(len_reg);
    assign inc_chunks = eff_chunks + CW'(1);
    assign complete   = (inc_chunks == CW'(CHUNKS)) || (sum_bytes >= {1'b0, osize_reg});

    assign rd_ok = (CMPW'(rslot_reg) < CMPW'(cur_chunks)) && (CMPW'(rslot_reg) < CMPW'(CHUNKS));

    assign base_addr = AW'(idx) * AW'(CHUNKS);
    assign wr_addr   = base_addr + AW'(eff_chunks);
    assign rd_addr   = base_addr + AW'(rslot_reg);

    assign stat.need_read = is_read && id_ok && rd_ok;
    assign stat.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        ready_after = ready_reg;
        if (id_ok && is_chunk && store && complete) begin
            ready_after[idx] = 1'b1;
        end
        if (id_ok && is_release) begin
            ready_after[idx] = 1'b0;
        end
    end

    assign mask_ext = {{crt_pkg::MASK_W{1'b0}}, ready_after};

    always_comb begin
        count_val = '0;
        if (id_ok && is_chunk) begin
            count_val = store ? inc_chunks : eff_chunks;
        end else if (id_ok && is_read) begin
            count_val = cur_chunks;
        end
    end

    assign count_ext = {{crt_pkg::CNT_OUT_W{1'b0}}, count_val};
    assign slot_ext  = {{crt_pkg::SLOT_OUT_W{1'b0}}, eff_chunks};

    // Entry table update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < IMAGES; i++) begin
                status_reg[i] <= crt_pkg::ENT_FREE;
                bytes_reg[i]  <= '0;
                chunks_reg[i] <= '0;
            end
            ready_reg <= '0;
        end else if (cmd.exec && id_ok) begin
            ready_reg <= ready_after;
            if (is_chunk) begin
                if (store) begin
                    bytes_reg[idx]  <= sum_bytes;
                    chunks_reg[idx] <= inc_chunks;
                    status_reg[idx] <= complete ? crt_pkg::ENT_READY : crt_pkg::ENT_OPEN;
                end else if (reopen) begin
                    chunks_reg[idx] <= '0;
                    status_reg[idx] <= crt_pkg::ENT_OPEN;
                end
            end else if (is_release) begin
                status_reg[idx] <= crt_pkg::ENT_FREE;
                bytes_reg[idx]  <= '0;
                chunks_reg[idx] <= '0;
            end
        end
    end

    // Descriptor memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.exec && id_ok && is_chunk && store) begin
            desc_mem[wr_addr] <= {handle_reg, off_reg, len_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            mem_q_reg <= desc_mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_accepted_reg     <= id_ok && is_chunk && store;
            res_slot_reg         <= (id_ok && is_chunk && store) ?
                                    slot_ext[crt_pkg::SLOT_OUT_W-1:0] : '0;
            res_object_ready_reg <= id_ok && is_chunk && store && complete;
            res_mask_reg         <= mask_ext[crt_pkg::MASK_W-1:0];
            res_hold_reg         <= id_ok && is_chunk && store && hold_reg;
            res_count_reg        <= count_ext[crt_pkg::CNT_OUT_W-1:0];
            res_desc_reg         <= '0;
            res_rejected_reg     <= (!id_ok && (is_chunk || is_read || is_release)) ||
                                    (id_ok && is_read && !rd_ok);
        end else if (cmd.fill) begin
            res_desc_reg <= mem_q_reg;
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_accepted_reg     <= res_accepted_reg;
            m_slot_reg         <= res_slot_reg;
            m_object_ready_reg <= res_object_ready_reg;
            m_mask_reg         <= res_mask_reg;
            m_hold_reg         <= res_hold_reg;
            m_count_reg        <= res_count_reg;
            m_desc_reg         <= res_desc_reg;
            m_rejected_reg     <= res_rejected_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_chunk_slot    = m_slot_reg;
    assign m_object_ready  = m_object_ready_reg;
    assign m_complete_mask = m_mask_reg;
    assign m_hold_flag     = m_hold_reg;
    assign m_chunk_count   = m_count_reg;
    assign m_desc_handle   = m_desc_reg[DESC_W-1 -: crt_pkg::HANDLE_W];
    assign m_desc_offset   = m_desc_reg[crt_pkg::LEN_W +: crt_pkg::OFF_W];
    assign m_desc_bytes    = m_desc_reg[crt_pkg::LEN_W-1:0];
    assign m_rejected      = m_rejected_reg;

endmodule

`default_nettype wire

### rtl/chunk_reassembly_tracker.sv
// Top level of the chunk reassembly tracker: controller and datapath joined by command
// and status structs. Depends on crt_pkg, crt_ctrl and crt_dp.
`default_nettype none

// The tracker keeps one entry for each of IMAGES object ids and stores up to CHUNKS
// chunk descriptors per object in an internal memory of IMAGES*CHUNKS words. Each
// request is one transfer on the s_ channel and produces exactly one result transfer
// on the m_ channel. Requests are handled one at a time: a chunk arrival, a release,
// a rejected or an unknown request passes through the execute and commit states before
// the next possible transfer, and a read of a written slot also through the read state,
// because the descriptor memory has a registered read port. Every item goes
// through a single read-modify-write of its table entry in the execute state. A
// finished result sits in an output register, so a new request can be taken while
// the previous result waits for m_ready; a result stalls only if the one before it
// has still not been taken. Configuration writes are taken on the cfg_ channel in
// any cycle and should only be issued while no request is in flight. After reset the
// entry table is empty and no clearing pass is needed; descriptor words are only
// ever read from slots that have been written.
module chunk_reassembly_tracker #(
    parameter int IMAGES = crt_pkg::IMAGES_DEF,
    parameter int CHUNKS = crt_pkg::CHUNKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [crt_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Request channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [crt_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [crt_pkg::ID_W-1:0]          s_object_id,
    input  wire logic [crt_pkg::OFF_W-1:0]         s_chunk_offset,
    input  wire logic [crt_pkg::LEN_W-1:0]         s_chunk_bytes,
    input  wire logic [crt_pkg::HANDLE_W-1:0]      s_buffer_handle,
    input  wire logic [crt_pkg::RSLOT_W-1:0]       s_read_slot,
    // Result channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_accepted,
    output logic [crt_pkg::SLOT_OUT_W-1:0]         m_chunk_slot,
    output logic                                   m_object_ready,
    output logic [crt_pkg::MASK_W-1:0]             m_complete_mask,
    output logic                                   m_hold_flag,
    output logic [crt_pkg::CNT_OUT_W-1:0]          m_chunk_count,
    output logic [crt_pkg::HANDLE_W-1:0]           m_desc_handle,
    output logic [crt_pkg::OFF_W-1:0]              m_desc_offset,
    output logic [crt_pkg::LEN_W-1:0]              m_desc_bytes,
    output logic                                   m_rejected
);

    crt_pkg::crt_cmd_t  cmd;
    crt_pkg::crt_stat_t stat;

    // The controller steps each request through capture, execute, an optional
    // descriptor read and the hand-off to the output register.
    crt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath holds the configuration, the entry table, the descriptor
    // memory and both the result and the output registers.
    crt_dp #(
        .IMAGES (IMAGES),
        .CHUNKS (CHUNKS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_req_type      (s_req_type),
        .s_object_id     (s_object_id),
        .s_chunk_offset  (s_chunk_offset),
        .s_chunk_bytes   (s_chunk_bytes),
        .s_buffer_handle (s_buffer_handle),
        .s_read_slot     (s_read_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_chunk_slot    (m_chunk_slot),
        .m_object_ready  (m_object_ready),
        .m_complete_mask (m_complete_mask),
        .m_hold_flag     (m_hold_flag),
        .m_chunk_count   (m_chunk_count),
        .m_desc_handle   (m_desc_handle),
        .m_desc_offset   (m_desc_offset),
        .m_desc_bytes    (m_desc_bytes),
        .m_rejected      (m_rejected)
    );

`ifndef ASSERT_OFF
    // A request transfer is always followed by execution before another request is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while the previous one is executing");

    // Only a stored chunk can complete an object.
    a_ready_needs_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_object_ready) |-> (m_accepted && !m_rejected))
        else $error("object completion reported without a stored chunk");

    // The hold indication belongs to stored chunks only.
    a_hold_needs_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hold_flag) |-> m_accepted)
        else $error("hold flag on a result that stored nothing");

    // A stored chunk never carries descriptor read data.
    a_store_no_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (m_desc_handle == '0 && m_desc_bytes == '0))
        else $error("descriptor data on a chunk arrival result");
`endif

endmodule

`default_nettype wire
